FILE: design/olist_pkg.sv
`timescale 1ns / 1ps

package olist_pkg;

   localparam int DEPTH = 16;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   localparam int ACTION_W = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic [ACTION_W-1:0] ACT_APPEND   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_FRONT    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SEARCH   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RM_FRONT = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_RM_BACK  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] count_type;

   // map a list position onto a slot of the circular store
   function automatic addr_type olist_phys(addr_type head, count_type lidx);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(lidx);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

endpackage

FILE: design/olist_ram.sv
`timescale 1ns / 1ps

module olist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/ordered_list_engine_top.sv
`timescale 1ns / 1ps
// Append, insert front, removals and rejected requests are settled when taken; a search reads
// from position 0, one read a cycle, until the first hit or the last entry. Insert at p writes
// the value at once when p equals count; else the entries from p on move up one slot, last
// first, one entry moved a cycle through the store's single write port.
// One request in flight: the next is taken once the last result leaves its pending register.
// Reset (synchronous, active high) empties the list and drops pending results; stored values kept.
module ordered_list_engine_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // action[2:0], position[7:3], value[39:8]
   input  logic [olist_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status[1:0], found[2], match_index[6:3], entry_count[11:7], zero[15:12]
   output logic [olist_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import olist_pkg::*;

   localparam logic [1:0] STATE_IDLE  = 2'd0;
   localparam logic [1:0] STATE_SRCH  = 2'd1;
   localparam logic [1:0] STATE_SHIFT = 2'd2;

   logic [1:0]          state_ff, state_in;
   count_type           count_ff, count_in;
   addr_type            head_ff, head_in;
   count_type           pos_ff, pos_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   count_type           cur_ff, cur_in;
   logic                pend_ff, pend_in;
   count_type           pidx_ff, pidx_in;

   logic                res_pend_ff, res_pend_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_found_ff, res_found_in;
   logic [INDEX_W-1:0]  res_idx_ff, res_idx_in;
   logic [COUNT_W-1:0]  res_count_ff, res_count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                ram_we;
   addr_type            ram_waddr;
   logic [VALUE_W-1:0]  ram_wdata;
   addr_type            ram_raddr;
   logic [VALUE_W-1:0]  ram_rdata;

   logic                req_fire;
   logic [ACTION_W-1:0] r_act;
   logic [POS_W-1:0]    r_pos;
   logic [VALUE_W-1:0]  r_val;
   logic                full;
   logic                empty;
   logic                hit;
   logic                fin;
   logic [STATUS_W-1:0] fin_status;
   logic                fin_found;
   count_type           fin_idx;
   logic                move;

   olist_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign r_act = req_tdata[2:0];
   assign r_pos = req_tdata[7:3];
   assign r_val = req_tdata[39:8];

   assign req_tready = (state_ff == STATE_IDLE) && !res_pend_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign hit        = pend_ff && (ram_rdata == val_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      cur_in     = cur_ff;
      pend_in    = 1'b0;
      pidx_in    = pidx_ff;
      ram_we     = 1'b0;
      ram_waddr  = olist_phys(head_ff, count_ff);
      ram_wdata  = r_val;
      ram_raddr  = olist_phys(head_ff, cur_ff);
      fin        = 1'b0;
      fin_status = STATUS_OK;
      fin_found  = 1'b0;
      fin_idx    = '0;

      case (state_ff)
         STATE_IDLE: begin
            if (req_fire) begin
               pos_in = CW'(r_pos);
               val_in = r_val;
               cur_in = count_ff;
               fin    = 1'b1;
               case (r_act)
                  ACT_APPEND: begin
                     if (full) begin
                        fin_status = STATUS_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_FRONT: begin
                     if (full) begin
                        fin_status = STATUS_FULL;
                     end else begin
                        head_in   = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = head_in;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  ACT_INSERT: begin
                     if ((CW+POS_W)'(r_pos) > (CW+POS_W)'(count_ff)) begin
                        fin_status = STATUS_BADPOS;
                     end else if (full) begin
                        fin_status = STATUS_FULL;
                     end else begin
                        fin      = 1'b0;
                        state_in = STATE_SHIFT;
                     end
                  end
                  ACT_SEARCH: begin
                     fin      = 1'b0;
                     cur_in   = '0;
                     state_in = STATE_SRCH;
                  end
                  ACT_RM_FRONT: begin
                     if (empty) begin
                        fin_status = STATUS_EMPTY;
                     end else begin
                        head_in  = olist_phys(head_ff, CW'(1));
                        count_in = count_ff - 1'b1;
                     end
                  end
                  ACT_RM_BACK: begin
                     if (empty) begin
                        fin_status = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         STATE_SRCH: begin
            if (hit) begin
               fin       = 1'b1;
               fin_found = 1'b1;
               fin_idx   = pidx_ff;
               state_in  = STATE_IDLE;
            end else if (cur_ff < count_ff) begin
               ram_raddr = olist_phys(head_ff, cur_ff);
               pend_in   = 1'b1;
               pidx_in   = cur_ff;
               cur_in    = cur_ff + 1'b1;
            end else begin
               fin      = 1'b1;
               state_in = STATE_IDLE;
            end
         end
         STATE_SHIFT: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = olist_phys(head_ff, pidx_ff);
               ram_wdata = ram_rdata;
            end
            if (cur_ff > pos_ff) begin
               ram_raddr = olist_phys(head_ff, cur_ff - 1'b1);
               pend_in   = 1'b1;
               pidx_in   = cur_ff;
               cur_in    = cur_ff - 1'b1;
            end else if (!pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = olist_phys(head_ff, pos_ff);
               ram_wdata = val_ff;
               count_in  = count_ff + 1'b1;
               fin       = 1'b1;
               state_in  = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign move          = res_pend_ff && (!rsp_valid_ff || rsp_tready);
   assign res_pend_in   = fin ? 1'b1 : (move ? 1'b0 : res_pend_ff);
   assign res_status_in = fin ? fin_status : res_status_ff;
   assign res_found_in  = fin ? fin_found : res_found_ff;
   assign res_idx_in    = fin ? INDEX_W'(fin_idx) : res_idx_ff;
   assign res_count_in  = fin ? COUNT_W'(count_in) : res_count_ff;

   assign rsp_valid_in = move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = move ? {{(RSP_DATA_W - 12){1'b0}}, res_count_ff, res_idx_ff,
                                 res_found_ff, res_status_ff}
                              : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         pend_ff      <= 1'b0;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         pend_ff      <= pend_in;
         res_pend_ff  <= res_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      pidx_ff       <= pidx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_idx_ff    <= res_idx_in;
      res_count_ff  <= res_count_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_search_keeps_list: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_SRCH |=> $stable(count_ff) && $stable(head_ff))
      else $error("list changed during search");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res_pend_ff && rsp_valid_ff && !rsp_tready |=> res_pend_ff)
      else $error("pending result dropped");

   a_walk_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff != STATE_IDLE |-> !res_pend_ff)
      else $error("walk started with a result pending");

endmodule
